// File: src/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types for the sliding window median filter.
// No dependencies.
package swm_pkg;

  // Status a sorted cell exposes to its neighbors.
  typedef struct packed {
    logic valid;  // cell holds a sample
    logic gt;     // cell is empty or holds a value above the incoming key
    logic rb;     // evicted sample sits in this cell or one to its left
  } cell_flags_t;

endpackage

// File: src/swm_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted window: holds a sample and its age.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 step,
  input  logic                 full,
  input  logic [AW-1:0]        rem_age,
  input  logic signed [DW-1:0] key,
  input  cell_flags_t          l_flags,
  input  logic signed [DW-1:0] l_data,
  input  logic [AW-1:0]        l_age,
  input  cell_flags_t          r_flags,
  input  logic signed [DW-1:0] r_data,
  input  logic [AW-1:0]        r_age,
  output cell_flags_t          flags,
  output logic signed [DW-1:0] data,
  output logic [AW-1:0]        age
);

  logic                 valid;
  logic                 gt;
  logic                 rm;
  logic                 rb;
  logic signed [DW-1:0] data_next;
  logic [AW-1:0]        age_next;

  assign gt = !valid || (data > key);
  assign rm = full && valid && (age == rem_age);
  assign rb = l_flags.rb || rm;

  assign flags.valid = valid;
  assign flags.gt    = gt;
  assign flags.rb    = rb;

  always_comb begin
    data_next = data;
    age_next  = AW'(age + 1'b1);
    if (!rb) begin
      // left of the eviction: shift right past the insert point
      if (gt) begin
        if (l_flags.gt) begin
          data_next = l_data;
          age_next  = AW'(l_age + 1'b1);
        end else begin
          data_next = key;
          age_next  = '0;
        end
      end
    end else if (!l_flags.rb && l_flags.gt) begin
      data_next = l_data;
      age_next  = AW'(l_age + 1'b1);
    end else if (!r_flags.gt) begin
      // right of the eviction: close the gap
      data_next = r_data;
      age_next  = AW'(r_age + 1'b1);
    end else if (!l_flags.rb || !gt) begin
      data_next = key;
      age_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (step && !full) begin
      valid <= valid || l_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data <= data_next;
      age  <= age_next;
    end
  end

endmodule

// File: src/sliding_window_median.sv
`timescale 1ns / 1ps
// Running lower median over the last window_size samples (0 taken as 1, capped at WINDOW_MAX).
// Pipeline: cells and pend are registered, then median, which waits on back-pressure.
// Throughput: one sample per cycle unless output back-pressure holds in_ready low.
// Reset: window size 1, window empty, no request pending.
// A window_size write empties the window. Depends on swm_pkg and swm_cell.
module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [6:0]                     window_size,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] median
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CW-1:0] wsize;
  logic [CW-1:0] cfg_eff;
  logic [AW-1:0] mid;
  logic [AW-1:0] rem_age;
  logic [CW-1:0] fill;
  logic          full;
  logic          emit;
  logic          step;
  logic          clear;
  logic          pend;
  logic          adv;

  cell_flags_t                 fl [WINDOW_MAX+2];
  logic signed [SAMPLE_WIDTH-1:0] cd [WINDOW_MAX+2];
  logic [AW-1:0]               ca [WINDOW_MAX+2];
  logic [WINDOW_MAX-1:0]       valid_vec;

  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && cfg_ready;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = !pend || adv;
  assign step      = in_valid && in_ready;
  assign full      = (fill == wsize);
  assign emit      = full || (CW'(fill + 1'b1) == wsize);

  always_comb begin
    if (window_size == 7'd0) begin
      cfg_eff = CW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      cfg_eff = CW'(WINDOW_MAX);
    end else begin
      cfg_eff = CW'(window_size);
    end
  end

  // boundary cells: always-full on the left, always-empty on the right
  assign fl[0] = '{valid: 1'b1, gt: 1'b0, rb: 1'b0};
  assign cd[0] = '0;
  assign ca[0] = '0;
  assign fl[WINDOW_MAX+1] = '{valid: 1'b0, gt: 1'b1, rb: 1'b0};
  assign cd[WINDOW_MAX+1] = '0;
  assign ca[WINDOW_MAX+1] = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell #(
      .DW (SAMPLE_WIDTH),
      .AW (AW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .step    (step),
      .full    (full),
      .rem_age (rem_age),
      .key     (sample),
      .l_flags (fl[i]),
      .l_data  (cd[i]),
      .l_age   (ca[i]),
      .r_flags (fl[i+2]),
      .r_data  (cd[i+2]),
      .r_age   (ca[i+2]),
      .flags   (fl[i+1]),
      .data    (cd[i+1]),
      .age     (ca[i+1])
    );
    assign valid_vec[i] = fl[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize   <= CW'(1);
      mid     <= '0;
      rem_age <= '0;
      fill    <= '0;
    end else if (clear) begin
      wsize   <= cfg_eff;
      mid     <= AW'((cfg_eff - 1'b1) >> 1);
      rem_age <= AW'(cfg_eff - 1'b1);
      fill    <= '0;
    end else if (step && !full) begin
      fill <= CW'(fill + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        pend <= emit;
      end else if (adv) begin
        pend <= 1'b0;
      end
      if (adv) begin
        out_valid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pend) begin
      median <= cd[32'(mid) + 1];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= wsize)
    else $error("fill count above window size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("occupied cells disagree with fill count");

  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    step && full |-> fl[WINDOW_MAX].rb)
    else $error("no cell holds the oldest sample");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    pend && !adv |=> pend)
    else $error("pending median dropped under back-pressure");

endmodule
